@@ design/apxc_pkg.sv @@
`default_nettype none

package apxc_pkg;

    // Default frame length limit, in bytes from start to end delimiter.
    localparam int unsigned APXC_MAX_FRAME_LEN_DEF = 16;

    // Reset values of the configuration registers.
    localparam logic [7:0] START_DELIM_RST  = 8'h24;
    localparam logic [7:0] CHK_MARKER_RST   = 8'h21;
    localparam logic [7:0] END_DELIM_RST    = 8'h0A;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_DELIM  = 2'd0;
    localparam logic [1:0] CFG_CHK_MARKER   = 2'd1;
    localparam logic [1:0] CFG_END_DELIM    = 2'd2;

    // Frame status codes.
    localparam logic [1:0] STATUS_GOOD      = 2'd0;
    localparam logic [1:0] STATUS_NO_CHK    = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH  = 2'd2;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd3;

    // Checksum phase codes.
    localparam logic [1:0] PH_BODY          = 2'd0;
    localparam logic [1:0] PH_HIGH          = 2'd1;
    localparam logic [1:0] PH_LOW           = 2'd2;
    localparam logic [1:0] PH_DONE          = 2'd3;

    // One result transaction.
    typedef struct packed {
        logic       in_frame;
        logic       frame_done;
        logic [1:0] frame_status;
        logic [4:0] frame_length;
        logic [7:0] computed_checksum;
    } apxc_result_t;

    // Uppercase ASCII hex character for a nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10)
        begin
            res = 8'h30 + {4'd0, nib};
        end
        else
        begin
            res = 8'h37 + {4'd0, nib};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/ascii_packet_xor_checker_core.sv @@
`default_nettype none

// Channel   Direction  Handshake             Payload
// rx        in         rx_valid / rx_stall   rx_byte
// res       out        res_valid / res_stall in_frame, frame_done, frame_status,
//                                            frame_length, computed_checksum
// cfg       in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Every received byte produces exactly one result transaction, which passes
// through the input register and the result register. One byte per cycle is
// sustained unless the result side stalls: the frame state is a handful of
// registers that a single pass of logic updates between those two registers.
// Reset clears the frame state and loads the default delimiters. A stall on
// the result side holds the result register at once, and it stalls the input
// as soon as the input register also holds a byte.

module ascii_packet_xor_checker_core
    import apxc_pkg::*;
#(
    parameter int unsigned MAX_FRAME_LEN = APXC_MAX_FRAME_LEN_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       rx_valid,
    output logic            rx_stall,
    input  wire logic [7:0] rx_byte,

    output logic            res_valid,
    input  wire logic       res_stall,
    output logic            in_frame,
    output logic            frame_done,
    output logic [1:0]      frame_status,
    output logic [4:0]      frame_length,
    output logic [7:0]      computed_checksum,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    // The byte counter holds values up to MAX_FRAME_LEN inclusive.
    localparam int unsigned CW = $clog2(MAX_FRAME_LEN + 1);
    localparam logic [CW-1:0] MAX_LEN = CW'(MAX_FRAME_LEN);

    // Configuration registers.
    logic [7:0] start_delim_reg;
    logic [7:0] chk_marker_reg;
    logic [7:0] end_delim_reg;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Frame state.
    logic          frame_open_reg,  frame_open_next;
    logic [1:0]    phase_reg,       phase_next;
    logic [7:0]    xor_reg,         xor_next;
    logic          mismatch_reg,    mismatch_next;
    logic [CW-1:0] count_reg,       count_next;
    logic          overflow_reg,    overflow_next;

    // Result register.
    logic         out_valid_reg;
    apxc_result_t result_reg, result_next;

    logic         out_load;
    logic         advance;
    logic [CW+4:0] count_ext;

    // Configuration writes are taken at any time; the user writes only while
    // the block is idle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delim_reg <= START_DELIM_RST;
            chk_marker_reg  <= CHK_MARKER_RST;
            end_delim_reg   <= END_DELIM_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_DELIM: start_delim_reg <= cfg_data;
                CFG_CHK_MARKER:  chk_marker_reg  <= cfg_data;
                CFG_END_DELIM:   end_delim_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // The result register can take a new value when it is empty or being
    // drained this cycle. The input register moves forward whenever the
    // result register can load, so the input stalls only when both hold data.
    assign out_load = !out_valid_reg || !res_stall;
    assign advance  = in_valid_reg && out_load;
    assign rx_stall = in_valid_reg && !out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!rx_stall)
        begin
            in_valid_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!rx_stall && rx_valid)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // Frame tracking for the byte in the input register. The start delimiter
    // takes precedence over the end delimiter, which takes precedence over
    // the checksum marker.
    always_comb
    begin
        frame_open_next = frame_open_reg;
        phase_next      = phase_reg;
        xor_next        = xor_reg;
        mismatch_next   = mismatch_reg;
        count_next      = count_reg;
        overflow_next   = overflow_reg;
        result_next     = '0;

        if (in_byte_reg == start_delim_reg)
        begin
            // A start byte opens a frame, or restarts one that is open.
            frame_open_next      = 1'b1;
            phase_next           = PH_BODY;
            xor_next             = in_byte_reg;
            mismatch_next        = 1'b0;
            count_next           = CW'(1);
            overflow_next        = 1'b0;
            result_next.in_frame = 1'b1;
        end
        else if (frame_open_reg)
        begin
            result_next.in_frame = 1'b1;

            // The length saturates at the limit and flags the frame as too long.
            if (count_reg < MAX_LEN)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end

            if (in_byte_reg == end_delim_reg)
            begin
                frame_open_next        = 1'b0;
                result_next.frame_done = 1'b1;
                if (overflow_next)
                begin
                    result_next.frame_status = STATUS_TOO_LONG;
                end
                else if (phase_reg == PH_BODY)
                begin
                    result_next.frame_status = STATUS_NO_CHK;
                end
                else if (phase_reg != PH_DONE || mismatch_reg)
                begin
                    // This also covers a frame that ends before both digits.
                    result_next.frame_status = STATUS_MISMATCH;
                end
                else
                begin
                    result_next.frame_status = STATUS_GOOD;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_BODY:
                    begin
                        if (in_byte_reg == chk_marker_reg)
                        begin
                            phase_next = PH_HIGH;
                        end
                        else
                        begin
                            xor_next = xor_reg ^ in_byte_reg;
                        end
                    end
                    PH_HIGH:
                    begin
                        if (in_byte_reg != hex_digit(xor_reg[7:4]))
                        begin
                            mismatch_next = 1'b1;
                        end
                        phase_next = PH_LOW;
                    end
                    PH_LOW:
                    begin
                        if (in_byte_reg != hex_digit(xor_reg[3:0]))
                        begin
                            mismatch_next = 1'b1;
                        end
                        phase_next = PH_DONE;
                    end
                    PH_DONE:
                    begin
                        // Bytes after the digits only count toward the length.
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // Length and checksum are reported only for bytes inside a frame.
        if (result_next.in_frame)
        begin
            result_next.frame_length      = count_ext[4:0];
            result_next.computed_checksum = xor_next;
        end
    end

    // Widen first so the low five bits exist for any counter width.
    assign count_ext = {5'd0, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            phase_reg      <= PH_BODY;
            xor_reg        <= 8'd0;
            mismatch_reg   <= 1'b0;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
        end
        else if (advance)
        begin
            frame_open_reg <= frame_open_next;
            phase_reg      <= phase_next;
            xor_reg        <= xor_next;
            mismatch_reg   <= mismatch_next;
            count_reg      <= count_next;
            overflow_reg   <= overflow_next;
        end
    end

    // Result register: holds its transaction while the result side stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign res_valid         = out_valid_reg;
    assign in_frame          = result_reg.in_frame;
    assign frame_done        = result_reg.frame_done;
    assign frame_status      = result_reg.frame_status;
    assign frame_length      = result_reg.frame_length;
    assign computed_checksum = result_reg.computed_checksum;

endmodule

`default_nettype wire

@@ dv/apxc_frame_scoreboard_pkg.sv @@
`default_nettype none

package apxc_frame_scoreboard_pkg;
    import apxc_pkg::*;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_UPPER = 8'h41;

    // Tracks the frame checker state on the stimulus side and holds the results
    // that the accepted bytes must produce, oldest first.
    class frame_scoreboard;
        int unsigned  len_limit;
        logic [7:0]   start_delim;
        logic [7:0]   chk_marker;
        logic [7:0]   end_delim;
        logic         open_flag;
        logic         digit_bad;
        logic         overflow;
        logic [1:0]   phase;
        logic [7:0]   xor_acc;
        int unsigned  count;
        apxc_result_t pending_q[$];
        int unsigned  mismatches;
        int unsigned  bytes_seen;
        int unsigned  results_seen;
        int unsigned  closed_by_status[4];

        function new(int unsigned max_len);
            len_limit   = max_len;
            start_delim = START_DELIM_RST;
            chk_marker  = CHK_MARKER_RST;
            end_delim   = END_DELIM_RST;
            open_flag   = 1'b0;
            digit_bad   = 1'b0;
            overflow    = 1'b0;
            phase       = PH_BODY;
            xor_acc     = 8'h00;
            count       = 0;
        endfunction

        function logic [7:0] ascii_hex(input logic [3:0] nib);
            if (nib < 4'd10)
            begin
                return ASCII_ZERO + {4'h0, nib};
            end
            return ASCII_UPPER + {4'h0, nib - 4'd10};
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [7:0] value);
            case (idx)
                CFG_START_DELIM: start_delim = value;
                CFG_CHK_MARKER:  chk_marker  = value;
                CFG_END_DELIM:   end_delim   = value;
                default: ;
            endcase
        endfunction

        // Advances the frame state by one accepted byte and queues its result.
        function void note_byte(input logic [7:0] rx);
            apxc_result_t want;
            logic [1:0]   st;
            want = '0;
            st   = STATUS_GOOD;
            bytes_seen++;
            if (rx == start_delim)
            begin
                open_flag = 1'b1;
                phase     = PH_BODY;
                xor_acc   = rx;
                digit_bad = 1'b0;
                count     = 1;
                overflow  = 1'b0;
                want.in_frame = 1'b1;
            end
            else if (open_flag)
            begin
                want.in_frame = 1'b1;
                if (count < len_limit)
                begin
                    count++;
                end
                else
                begin
                    overflow = 1'b1;
                end
                if (rx == end_delim)
                begin
                    open_flag = 1'b0;
                    if (overflow)
                        st = STATUS_TOO_LONG;
                    else if (phase == PH_BODY)
                        st = STATUS_NO_CHK;
                    else if (phase != PH_DONE || digit_bad)
                        st = STATUS_MISMATCH;
                    want.frame_done   = 1'b1;
                    want.frame_status = st;
                    closed_by_status[st]++;
                end
                else
                begin
                    case (phase)
                        PH_BODY:
                        begin
                            if (rx == chk_marker)
                                phase = PH_HIGH;
                            else
                                xor_acc = xor_acc ^ rx;
                        end
                        PH_HIGH:
                        begin
                            if (rx != ascii_hex(xor_acc[7:4]))
                                digit_bad = 1'b1;
                            phase = PH_LOW;
                        end
                        PH_LOW:
                        begin
                            if (rx != ascii_hex(xor_acc[3:0]))
                                digit_bad = 1'b1;
                            phase = PH_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            if (want.in_frame)
            begin
                want.frame_length      = 5'(count);
                want.computed_checksum = xor_acc;
            end
            pending_q.push_back(want);
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            $display("MISMATCH at result %0d: %s", results_seen, what);
        endtask

        task check_result(input apxc_result_t got);
            apxc_result_t want;
            results_seen++;
            if (pending_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = pending_q.pop_front();
            if (got.in_frame !== want.in_frame)
                report_mismatch($sformatf("in_frame got %0h expected %0h",
                                          got.in_frame, want.in_frame));
            if (got.frame_done !== want.frame_done)
                report_mismatch($sformatf("frame_done got %0h expected %0h",
                                          got.frame_done, want.frame_done));
            if (got.frame_status !== want.frame_status)
                report_mismatch($sformatf("frame_status got %0h expected %0h",
                                          got.frame_status, want.frame_status));
            if (got.frame_length !== want.frame_length)
                report_mismatch($sformatf("frame_length got %0d expected %0d",
                                          got.frame_length, want.frame_length));
            if (got.computed_checksum !== want.computed_checksum)
                report_mismatch($sformatf("computed_checksum got %h expected %h",
                                          got.computed_checksum,
                                          want.computed_checksum));
        endtask
    endclass

endpackage

`default_nettype wire

@@ dv/tb_ascii_packet_xor_checker_core.sv @@
`default_nettype none

module tb_ascii_packet_xor_checker_core;
    import apxc_pkg::*;
    import apxc_frame_scoreboard_pkg::*;

    localparam int unsigned FRAME_LIMIT  = APXC_MAX_FRAME_LEN_DEF;
    localparam int unsigned PHASE_COUNT  = 8;
    localparam int unsigned PHASE_BYTES  = 130;

    // Kinds of frame that the random part builds. Most are well formed so that
    // the checker reaches its digit phases; the rest break the frame on purpose.
    typedef enum int unsigned {
        FR_GOOD,
        FR_BAD_HIGH,
        FR_BAD_LOW,
        FR_NO_CHK,
        FR_SHORT_CHK,
        FR_MARKER_DIGIT,
        FR_TRAILING,
        FR_RESTART
    } frame_kind_t;

    // Directed bytes under the reset delimiters ($, !, LF). They cover bytes
    // outside a frame at both extremes, a good frame, a frame without a
    // checksum that carries 0xFF, a marker followed directly by the end byte,
    // a start byte inside an open frame, and the marker sent as a digit.
    localparam int unsigned DIRECTED_LEN = 26;
    localparam logic [7:0] DIRECTED_BYTES [DIRECTED_LEN] = '{
        8'h00, 8'hFF,
        8'h24, 8'h47, 8'h50, 8'h21, 8'h33, 8'h33, 8'h0A,
        8'h24, 8'hFF, 8'h0A,
        8'h24, 8'h00, 8'h21, 8'h0A,
        8'h24, 8'h41, 8'h24, 8'h42, 8'h0A,
        8'h24, 8'h21, 8'h21, 8'h30, 8'h0A
    };

    // Delimiter settings per phase: start, marker, end. Phase 0 runs on the
    // reset values and is never written. Start and marker reach both extremes,
    // every pairing of equal delimiters occurs, and the last restores defaults.
    localparam logic [7:0] PHASE_START [PHASE_COUNT] =
        '{8'h24, 8'h00, 8'hFF, 8'h3A, 8'h40, 8'h24, 8'h5E, 8'h24};
    localparam logic [7:0] PHASE_MARKER [PHASE_COUNT] =
        '{8'h21, 8'hFF, 8'h00, 8'h2A, 8'h40, 8'h0A, 8'h21, 8'h21};
    localparam logic [7:0] PHASE_END [PHASE_COUNT] =
        '{8'h0A, 8'h7F, 8'h0D, 8'h0D, 8'h0A, 8'h0A, 8'h5E, 8'h0A};

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       rx_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       res_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [1:0] cfg_index = CFG_START_DELIM;
    logic [7:0] cfg_data  = 8'h00;

    logic       rx_stall;
    logic       res_valid;
    logic       in_frame;
    logic       frame_done;
    logic [1:0] frame_status;
    logic [4:0] frame_length;
    logic [7:0] computed_checksum;
    logic       cfg_ready;

    // Idle rates in percent: idle input cycles and stalled result cycles.
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;

    frame_scoreboard sb;

    ascii_packet_xor_checker_core #(
        .MAX_FRAME_LEN (FRAME_LIMIT)
    ) uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .rx_valid          (rx_valid),
        .rx_stall          (rx_stall),
        .rx_byte           (rx_byte),
        .res_valid         (res_valid),
        .res_stall         (res_stall),
        .in_frame          (in_frame),
        .frame_done        (frame_done),
        .frame_status      (frame_status),
        .frame_length      (frame_length),
        .computed_checksum (computed_checksum),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #6 clk = ~clk;

    // Result side. Outputs are read at the rising edge, before the block's own
    // updates of that edge land, so a transaction is seen exactly when valid is
    // high and our stall was low during the cycle just ended. The next stall
    // decision is made at the same edge.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            res_stall <= ($urandom_range(99) < stall_pct);
            if (res_valid && !res_stall)
                sb.check_result({in_frame, frame_done, frame_status,
                                 frame_length, computed_checksum});
        end
    end

    // Offers one byte and waits until the block takes it. Each cycle before
    // the offer is idle with probability gap_pct, so valid drops right after
    // the previous transaction for as many cycles as are drawn; otherwise
    // valid simply stays high and only the payload moves on.
    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(99) < gap_pct)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= value;
        @(posedge clk);
        while (rx_stall) @(posedge clk);
        sb.note_byte(value);
    endtask

    // The sender pauses until every pending result has been checked. Extra
    // cycles then cover the two-stage pipeline before any register write.
    task automatic wait_idle();
        rx_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register transaction; valid is left high so that back-to-back writes
    // do not lower and raise it in the same step.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    task automatic load_delimiters(input logic [7:0] start_b, input logic [7:0] marker_b,
                                   input logic [7:0] end_b);
        write_reg(CFG_START_DELIM, start_b);
        write_reg(CFG_CHK_MARKER, marker_b);
        write_reg(CFG_END_DELIM, end_b);
        cfg_valid <= 1'b0;
    endtask

    // A random byte that matches none of the current delimiters, so the body
    // of a well-formed frame stays in the body phase.
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == sb.start_delim || b == sb.chk_marker || b == sb.end_delim);
        return b;
    endfunction

    // Builds one frame of the given kind. The running XOR is kept here so that
    // good frames carry correct digits; corrupted digits flip at least one bit.
    task automatic send_frame(input frame_kind_t kind, input int unsigned body_len);
        logic [7:0]  acc;
        logic [7:0]  b;
        logic [7:0]  hi;
        logic [7:0]  lo;
        int unsigned i;
        if (kind == FR_RESTART)
        begin
            send_byte(sb.start_delim);
            repeat ($urandom_range(1, 3)) send_byte(body_byte());
        end
        acc = sb.start_delim;
        send_byte(sb.start_delim);
        for (i = 0; i < body_len; i++)
        begin
            b   = body_byte();
            acc = acc ^ b;
            send_byte(b);
        end
        hi = sb.ascii_hex(acc[7:4]);
        lo = sb.ascii_hex(acc[3:0]);
        case (kind)
            FR_NO_CHK: ;
            FR_SHORT_CHK:
            begin
                // Zero or one digit before the end byte.
                send_byte(sb.chk_marker);
                if ($urandom_range(1))
                    send_byte(hi);
            end
            FR_MARKER_DIGIT:
            begin
                send_byte(sb.chk_marker);
                if ($urandom_range(1))
                begin
                    send_byte(sb.chk_marker);
                    send_byte(lo);
                end
                else
                begin
                    send_byte(hi);
                    send_byte(sb.chk_marker);
                end
            end
            default:
            begin
                if (kind == FR_BAD_HIGH)
                    hi = hi ^ 8'($urandom_range(1, 255));
                if (kind == FR_BAD_LOW)
                    lo = lo ^ 8'($urandom_range(1, 255));
                send_byte(sb.chk_marker);
                send_byte(hi);
                send_byte(lo);
                if (kind == FR_TRAILING)
                    repeat ($urandom_range(1, 3)) send_byte(body_byte());
            end
        endcase
        send_byte(sb.end_delim);
    endtask

    // Random frames with an occasional run of unconstrained bytes between
    // them. Bodies are mostly short; about one in eight is drawn from 9 to 20
    // bytes, long enough for some frames to pass the frame length limit.
    task automatic random_traffic(input int unsigned goal);
        int unsigned pick;
        int unsigned body_len;
        frame_kind_t kind;
        while (sb.bytes_seen < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 55)      kind = FR_GOOD;
            else if (pick < 62) kind = FR_BAD_HIGH;
            else if (pick < 69) kind = FR_BAD_LOW;
            else if (pick < 77) kind = FR_NO_CHK;
            else if (pick < 83) kind = FR_SHORT_CHK;
            else if (pick < 88) kind = FR_MARKER_DIGIT;
            else if (pick < 94) kind = FR_TRAILING;
            else                kind = FR_RESTART;
            if ($urandom_range(7) == 0)
                body_len = $urandom_range(9, 20);
            else
                body_len = $urandom_range(0, 8);
            send_frame(kind, body_len);
            if ($urandom_range(99) < 30)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        int unsigned p;
        sb = new(FRAME_LIMIT);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idling schedule: first a mostly busy sender against a slow receiver,
        // then the reverse, then both sides at full rate.
        gap_pct   = 6;
        stall_pct = 48;
        for (p = 0; p < DIRECTED_LEN; p++)
            send_byte(DIRECTED_BYTES[p]);

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            if (p == 3)
            begin
                gap_pct   = 48;
                stall_pct = 6;
            end
            else if (p == 6)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            if (p != 0)
            begin
                wait_idle();
                load_delimiters(PHASE_START[p], PHASE_MARKER[p], PHASE_END[p]);
            end
            random_traffic(sb.bytes_seen + PHASE_BYTES);
        end

        wait_idle();
        repeat (8) @(posedge clk);

        $display("Summary: %0d bytes under %0d delimiter settings, %0d results checked.",
                 sb.bytes_seen, PHASE_COUNT, sb.results_seen);
        $display("Frames closed: %0d good, %0d without checksum, %0d mismatched, %0d too long.",
                 sb.closed_by_status[STATUS_GOOD], sb.closed_by_status[STATUS_NO_CHK],
                 sb.closed_by_status[STATUS_MISMATCH], sb.closed_by_status[STATUS_TOO_LONG]);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of a little over a thousand
    // bytes with heavy gaps and stalls.
    initial
    begin
        #2400000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
